@@ rtl/psbm_pkg.sv @@
// psbm_pkg: shared types and constants of the patch ssd best-match block
`default_nettype none

package psbm_pkg;

   // field widths
   localparam int CHAN_W  = 8;
   localparam int COORD_W = 12;
   localparam int DIST_W  = 31;
   localparam int SUM_W   = 24;
   localparam int SQ_W    = 18;

   // stream widths, rounded up to whole bytes
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 88;

   // request kind carried on req_tuser
   typedef enum logic {
      REQ_BEGIN = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   // registered item handed from the input stage to the scoring stage
   typedef struct packed {
      logic                valid;
      req_kind_type        kind;
      logic                last;
      logic [SQ_W-1:0]     sq_sum;
      logic [COORD_W-1:0]  cand_x;
      logic [COORD_W-1:0]  cand_y;
      logic [DIST_W-1:0]   start_dist;
   } item_type;

endpackage

`default_nettype wire

@@ rtl/psbm_sqdiff.sv @@
// psbm_sqdiff: sum of squared rgb differences of one pixel pair
`default_nettype none

module psbm_sqdiff (
   input  wire logic [psbm_pkg::CHAN_W-1:0] a_red,
   input  wire logic [psbm_pkg::CHAN_W-1:0] a_green,
   input  wire logic [psbm_pkg::CHAN_W-1:0] a_blue,
   input  wire logic [psbm_pkg::CHAN_W-1:0] b_red,
   input  wire logic [psbm_pkg::CHAN_W-1:0] b_green,
   input  wire logic [psbm_pkg::CHAN_W-1:0] b_blue,
   output logic      [psbm_pkg::SQ_W-1:0]   sq_sum
);

   localparam int SQ1_W = 2 * psbm_pkg::CHAN_W;

   logic [psbm_pkg::CHAN_W-1:0] diff_r, diff_g, diff_b;
   logic [SQ1_W-1:0]            sq_r, sq_g, sq_b;

   // absolute differences per channel
   always_comb begin
      diff_r = (a_red   >= b_red)   ? a_red   - b_red   : b_red   - a_red;
      diff_g = (a_green >= b_green) ? a_green - b_green : b_green - a_green;
      diff_b = (a_blue  >= b_blue)  ? a_blue  - b_blue  : b_blue  - a_blue;
   end

   // squares and their sum
   always_comb begin
      sq_r   = SQ1_W'(diff_r) * SQ1_W'(diff_r);
      sq_g   = SQ1_W'(diff_g) * SQ1_W'(diff_g);
      sq_b   = SQ1_W'(diff_b) * SQ1_W'(diff_b);
      sq_sum = psbm_pkg::SQ_W'(sq_r) + psbm_pkg::SQ_W'(sq_g) + psbm_pkg::SQ_W'(sq_b);
   end

endmodule

`default_nettype wire

@@ rtl/psbm_score.sv @@
// psbm_score: running sum, best-match state and result register
`default_nettype none

module psbm_score #(
   parameter int KEEP_BITS = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire psbm_pkg::item_type                   item,
   output logic                                      advance,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [psbm_pkg::RSP_TDATA_W-1:0]          rsp_tdata
);

   localparam int DIST_W  = psbm_pkg::DIST_W;
   localparam int SUM_W   = psbm_pkg::SUM_W;
   localparam int COORD_W = psbm_pkg::COORD_W;
   localparam int PAD_W   = psbm_pkg::RSP_TDATA_W - (2 * DIST_W + 1 + 2 * COORD_W);

   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [DIST_W-1:0]    best_ff, best_in;
   logic [KEEP_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [psbm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_sat;
   logic [DIST_W-1:0]    sum_ext, cand;
   logic                 better, take, emit;

   // the pipe moves while the result register is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign take       = item.valid && advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // saturating accumulate and clamp against the best
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(item.sq_sum);
      sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      sum_ext  = DIST_W'(sum_sat);
      cand     = (sum_ext < best_ff) ? sum_ext : best_ff;
      better   = cand < best_ff;
      emit     = take && (item.kind == psbm_pkg::REQ_PIXEL) && item.last;
   end

   // next state
   always_comb begin
      sum_in  = sum_ff;
      best_in = best_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (take) begin
         unique case (item.kind)
            psbm_pkg::REQ_BEGIN: begin
               best_in = item.start_dist;
               col_in  = item.cand_x[KEEP_BITS-1:0];
               row_in  = item.cand_y[KEEP_BITS-1:0];
               sum_in  = '0;
            end
            psbm_pkg::REQ_PIXEL: begin
               sum_in = item.last ? '0 : sum_sat;
               if (item.last && better) begin
                  best_in = cand;
                  col_in  = item.cand_x[KEEP_BITS-1:0];
                  row_in  = item.cand_y[KEEP_BITS-1:0];
               end
            end
            default: begin
               sum_in = sum_ff;
            end
         endcase
      end
   end

   // result beat: cand_dist, improved, best_dist, best_x, best_y from bit 0 up
   always_comb begin
      rsp_data_in = {{PAD_W{1'b0}}, COORD_W'(row_in), COORD_W'(col_in), best_in, better, cand};
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         best_ff      <= {DIST_W{1'b1}};
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/patch_ssd_best_match.sv @@
// patch_ssd_best_match: top level, input register feeding the scoring stage
// result: last pixel beat -> input register -> result register
// throughput: one beat per cycle unless a full result register waits on rsp_tready
// reset: synchronous, active high; clears the running sum, sets the best distance
// to all ones and the best coordinates to zero, and empties both pipe registers
`default_nettype none

module patch_ssd_best_match #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // a_red, a_green, a_blue, b_red, b_green, b_blue, cand_x, cand_y, start_dist
   input  wire logic [psbm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type
   input  wire logic                                req_tuser,
   // patch_last
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // cand_dist, improved, best_dist, best_x, best_y
   output logic [psbm_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   localparam int COORD_W   = psbm_pkg::COORD_W;
   localparam int CHAN_W    = psbm_pkg::CHAN_W;
   localparam int DIST_W    = psbm_pkg::DIST_W;
   localparam int KEEP_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int X_LO      = 6 * CHAN_W;
   localparam int Y_LO      = X_LO + COORD_W;
   localparam int D_LO      = Y_LO + COORD_W;

   logic                                 stage_valid_ff, stage_valid_in;
   logic [psbm_pkg::REQ_TDATA_W-1:0]     stage_data_ff;
   logic                                 stage_kind_ff, stage_last_ff;
   logic                                 advance, accept;
   logic [psbm_pkg::SQ_W-1:0]            sq_sum;
   psbm_pkg::item_type                   item;

   // input stage takes a beat when empty or moving on
   assign req_tready = !stage_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_data_ff <= req_tdata;
         stage_kind_ff <= req_tuser;
         stage_last_ff <= req_tlast;
      end
   end

   // pixel pair distance
   psbm_sqdiff u_sqdiff (
      .a_red   (stage_data_ff[0*CHAN_W +: CHAN_W]),
      .a_green (stage_data_ff[1*CHAN_W +: CHAN_W]),
      .a_blue  (stage_data_ff[2*CHAN_W +: CHAN_W]),
      .b_red   (stage_data_ff[3*CHAN_W +: CHAN_W]),
      .b_green (stage_data_ff[4*CHAN_W +: CHAN_W]),
      .b_blue  (stage_data_ff[5*CHAN_W +: CHAN_W]),
      .sq_sum  (sq_sum)
   );

   // item for the scoring stage
   always_comb begin
      item.valid      = stage_valid_ff;
      item.kind       = psbm_pkg::req_kind_type'(stage_kind_ff);
      item.last       = stage_last_ff;
      item.sq_sum     = sq_sum;
      item.cand_x     = stage_data_ff[X_LO +: COORD_W];
      item.cand_y     = stage_data_ff[Y_LO +: COORD_W];
      item.start_dist = stage_data_ff[D_LO +: DIST_W];
   end

   psbm_score #(
      .KEEP_BITS (KEEP_BITS)
   ) u_score (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
